### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define UKOL_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define UKOL_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UKOL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ukol_pkg.sv
// ----------------------------------------------------------------------------
// ukol_pkg
// Shared widths, operation codes and entry/memory types of the ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

package ukol_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int OP_W       = 3;
    localparam int KEY_W      = 31;
    localparam int GROUP_W    = 31;
    localparam int IDX_W      = 6;
    localparam int TOTAL_W    = 7;
    // Wide enough to address up to 1024 entries.
    localparam int MEM_ADDR_W = 10;

    localparam logic [OP_W-1:0] OP_ADD         = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE      = 3'd1;
    localparam logic [OP_W-1:0] OP_CONTAINS    = 3'd2;
    localparam logic [OP_W-1:0] OP_GET         = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_FLAG    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR_FLAGS = 3'd6;

    typedef struct packed {
        logic               flag;
        logic [GROUP_W-1:0] grp;
        logic [KEY_W-1:0]   key;
    } entry_t;

    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] waddr;
        entry_t                wdata;
        logic                  re;
        logic [MEM_ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

### sv/ukol_if.sv
// ----------------------------------------------------------------------------
// ukol_if
// Request and response channels of the ordered list (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface ukol_req_if import ukol_pkg::*;;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   item_key;
    logic [GROUP_W-1:0] group_id;
    logic [IDX_W-1:0]   entry_index;
    logic               flag_value;

    modport source (
        output valid, op, item_key, group_id, entry_index, flag_value,
        input  ready
    );
    modport sink (
        input  valid, op, item_key, group_id, entry_index, flag_value,
        output ready
    );
endinterface

interface ukol_rsp_if import ukol_pkg::*;;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [KEY_W-1:0]   out_key;
    logic [GROUP_W-1:0] out_group;
    logic               out_flag;
    logic [TOTAL_W-1:0] entry_total;

    modport source (
        output valid, ok, out_key, out_group, out_flag, entry_total,
        input  ready
    );
    modport sink (
        input  valid, ok, out_key, out_group, out_flag, entry_total,
        output ready
    );
endinterface

`default_nettype wire

### sv/unique_key_ordered_list_core.sv
// ----------------------------------------------------------------------------
// unique_key_ordered_list_core
// Steps: clear, unused codes and add to a full list go from decode to finish; get reads
//   its entry and set flag reads and rewrites it; add, remove, contains and clear flags
//   walk the held entries, a read and then a check or write for each entry visited.
// Flow: one request at a time; ready returns as the response loads, and a stalled
//   response holds the sequencer.
// Reset clears the entry count and the control state; entries are not swept.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module unique_key_ordered_list_core import ukol_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ukol_req_if.sink    req,
    ukol_rsp_if.source  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    // Common width for comparing the request index against the count.
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_GET_WAIT,
        S_SETF_WR,
        S_CLRF_RD,
        S_CLRF_WR,
        S_FINISH
    } state_t;

    state_t             state_reg,     state_next;
    logic [CW-1:0]      count_reg,     count_next;
    logic [CW-1:0]      ptr_reg,       ptr_next;

    // Latched request transaction.
    logic [OP_W-1:0]    op_reg,        op_next;
    logic [KEY_W-1:0]   key_reg,       key_next;
    logic [GROUP_W-1:0] grp_reg,       grp_next;
    logic [IDX_W-1:0]   idx_reg,       idx_next;
    logic               fval_reg,      fval_next;

    // Result being built by the sequencer.
    logic               res_ok_reg,    res_ok_next;
    logic [KEY_W-1:0]   res_key_reg,   res_key_next;
    logic [GROUP_W-1:0] res_grp_reg,   res_grp_next;
    logic               res_flag_reg,  res_flag_next;

    // Response output register; parts the sequencer from the consumer.
    logic               rsp_valid_reg, rsp_valid_next;
    logic               rsp_ok_reg,    rsp_ok_next;
    logic [KEY_W-1:0]   rsp_key_reg,   rsp_key_next;
    logic [GROUP_W-1:0] rsp_grp_reg,   rsp_grp_next;
    logic               rsp_flag_reg,  rsp_flag_next;
    logic [TOTAL_W-1:0] rsp_total_reg, rsp_total_next;

    mem_req_t           mem_req;
    entry_t             rd_entry;
    logic               key_match;

    logic [CW-1:0]      ptr_inc;
    logic [IW-1:0]      idx_ext;
    logic               idx_ok;

    assign ptr_inc = ptr_reg + 1'b1;
    assign idx_ext = IW'(idx_reg);
    // count never exceeds DEPTH, so this also bounds the index by the depth.
    assign idx_ok  = (idx_ext < IW'(count_reg));

    ukol_entry_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk       (clk),
        .mem_req   (mem_req),
        .cmp_key   (key_reg),
        .rd_entry  (rd_entry),
        .key_match (key_match)
    );

    // Sequencer: every step issues at most one memory access and one compare.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        grp_next       = grp_reg;
        idx_next       = idx_reg;
        fval_next      = fval_reg;
        res_ok_next    = res_ok_reg;
        res_key_next   = res_key_reg;
        res_grp_next   = res_grp_reg;
        res_flag_next  = res_flag_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_key_next   = rsp_key_reg;
        rsp_grp_next   = rsp_grp_reg;
        rsp_flag_next  = rsp_flag_reg;
        rsp_total_next = rsp_total_reg;
        mem_req        = '0;

        // Drop the response once the consumer takes it.
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next       = req.op;
                    key_next      = req.item_key;
                    grp_next      = req.group_id;
                    idx_next      = req.entry_index;
                    fval_next     = req.flag_value;
                    res_ok_next   = 1'b0;
                    res_key_next  = '0;
                    res_grp_next  = '0;
                    res_flag_next = 1'b0;
                    state_next    = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        // Full list: reject without searching.
                        if (count_reg == FULL_COUNT)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            state_next = S_SRCH_RD;
                        end
                    end
                    OP_REMOVE, OP_CONTAINS:
                    begin
                        ptr_next   = '0;
                        state_next = S_SRCH_RD;
                    end
                    OP_GET, OP_SET_FLAG:
                    begin
                        if (idx_ok)
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = MEM_ADDR_W'(idx_ext[AW-1:0]);
                            state_next    = (op_reg == OP_GET) ? S_GET_WAIT : S_SETF_WR;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    OP_CLEAR:
                    begin
                        // Stale entries sit above the count and are never read.
                        count_next  = '0;
                        res_ok_next = 1'b1;
                        state_next  = S_FINISH;
                    end
                    OP_CLEAR_FLAGS:
                    begin
                        ptr_next   = '0;
                        state_next = S_CLRF_RD;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_SRCH_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    // Key absent: an add appends at the tail.
                    if (op_reg == OP_ADD)
                    begin
                        mem_req.we         = 1'b1;
                        mem_req.waddr      = MEM_ADDR_W'(count_reg[AW-1:0]);
                        mem_req.wdata.flag = 1'b0;
                        mem_req.wdata.grp  = grp_reg;
                        mem_req.wdata.key  = key_reg;
                        count_next         = count_reg + 1'b1;
                        res_ok_next        = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = MEM_ADDR_W'(ptr_reg[AW-1:0]);
                    state_next    = S_SRCH_CHK;
                end
            end

            S_SRCH_CHK:
            begin
                if (key_match)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        // Hold ptr at the hit; compaction starts there.
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        // Duplicate add fails, contains succeeds.
                        res_ok_next = (op_reg == OP_CONTAINS);
                        state_next  = S_FINISH;
                    end
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SRCH_RD;
                end
            end

            S_SHIFT_RD:
            begin
                if (ptr_inc == count_reg)
                begin
                    count_next  = count_reg - 1'b1;
                    res_ok_next = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = MEM_ADDR_W'(ptr_inc[AW-1:0]);
                    state_next    = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_ADDR_W'(ptr_reg[AW-1:0]);
                mem_req.wdata = rd_entry;
                ptr_next      = ptr_inc;
                state_next    = S_SHIFT_RD;
            end

            S_GET_WAIT:
            begin
                res_ok_next   = 1'b1;
                res_key_next  = rd_entry.key;
                res_grp_next  = rd_entry.grp;
                res_flag_next = rd_entry.flag;
                state_next    = S_FINISH;
            end

            S_SETF_WR:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = MEM_ADDR_W'(idx_ext[AW-1:0]);
                mem_req.wdata      = rd_entry;
                mem_req.wdata.flag = fval_reg;
                res_ok_next        = 1'b1;
                state_next         = S_FINISH;
            end

            S_CLRF_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    res_ok_next = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = MEM_ADDR_W'(ptr_reg[AW-1:0]);
                    state_next    = S_CLRF_WR;
                end
            end

            S_CLRF_WR:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = MEM_ADDR_W'(ptr_reg[AW-1:0]);
                mem_req.wdata      = rd_entry;
                mem_req.wdata.flag = 1'b0;
                ptr_next           = ptr_inc;
                state_next         = S_CLRF_RD;
            end

            S_FINISH:
            begin
                // Load the response register once it is free or being drained.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = res_ok_reg;
                    rsp_key_next   = res_key_reg;
                    rsp_grp_next   = res_grp_reg;
                    rsp_flag_next  = res_flag_reg;
                    rsp_total_next = TOTAL_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            op_reg        <= '0;
            key_reg       <= '0;
            grp_reg       <= '0;
            idx_reg       <= '0;
            fval_reg      <= 1'b0;
            res_ok_reg    <= 1'b0;
            res_key_reg   <= '0;
            res_grp_reg   <= '0;
            res_flag_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_ok_reg    <= 1'b0;
            rsp_key_reg   <= '0;
            rsp_grp_reg   <= '0;
            rsp_flag_reg  <= 1'b0;
            rsp_total_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            op_reg        <= op_next;
            key_reg       <= key_next;
            grp_reg       <= grp_next;
            idx_reg       <= idx_next;
            fval_reg      <= fval_next;
            res_ok_reg    <= res_ok_next;
            res_key_reg   <= res_key_next;
            res_grp_reg   <= res_grp_next;
            res_flag_reg  <= res_flag_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_ok_reg    <= rsp_ok_next;
            rsp_key_reg   <= rsp_key_next;
            rsp_grp_reg   <= rsp_grp_next;
            rsp_flag_reg  <= rsp_flag_next;
            rsp_total_reg <= rsp_total_next;
        end
    end

    // Take a request transaction only while the sequencer is free.
    assign req.ready       = (state_reg == S_IDLE);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.out_key     = rsp_key_reg;
    assign rsp.out_group   = rsp_grp_reg;
    assign rsp.out_flag    = rsp_flag_reg;
    assign rsp.entry_total = rsp_total_reg;

    `UKOL_ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_COUNT,
        "entry count exceeds depth")

    `UKOL_ASSERT_IMPLIES(a_count_step, count_reg != $past(count_reg),
        (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1)
            || (count_reg == '0),
        "entry count moved by more than one")

    `UKOL_ASSERT_IMPLIES(a_write_in_range, mem_req.we, mem_req.waddr < DEPTH,
        "memory write beyond depth")

    `UKOL_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
        "request taken while a transaction is in progress")

endmodule

`default_nettype wire

### sv/ukol_entry_store.sv
// ----------------------------------------------------------------------------
// ukol_entry_store
// Entry memory with one write and one registered read port, plus the shared
// key comparator that the search walks through.
// ----------------------------------------------------------------------------
`default_nettype none

module ukol_entry_store import ukol_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire mem_req_t         mem_req,
    input  wire logic [KEY_W-1:0] cmp_key,
    output entry_t                rd_entry,
    output logic                  key_match
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rd_data_reg <= mem[mem_req.raddr[AW-1:0]];
        end
    end

    assign rd_entry  = rd_data_reg;
    assign key_match = (rd_data_reg.key == cmp_key);

endmodule

`default_nettype wire

### tb/sv/unique_key_ordered_list_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unique_key_ordered_list_core_tb
// Drives list requests over the request channel and scores every response
// against a local model of the deduplicating ordered list. A short directed
// part covers the empty, duplicate and out-of-range corners. A random
// part follows, built from fill bursts that can reach a full list, drain
// bursts and mixed operations. Keys are mostly drawn from a small pool,
// so that duplicates, hits and shifting removes happen often. Both
// channels idle at random until the tail of the run.
// ----------------------------------------------------------------------------

module unique_key_ordered_list_core_tb;
    import ukol_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int POOL_SIZE    = 80;
    localparam int RANDOM_ITEMS = 1030;
    localparam int TAIL_ITEMS   = 80;
    // Margin over the longest request, which walks the whole list.
    localparam int DRAIN_CYCLES = 4 * LIST_DEPTH + 40;
    localparam int CYCLE_LIMIT  = 1_500_000;

    // The one code that the package leaves unnamed: no operation.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [GROUP_W-1:0] grp;
        logic [IDX_W-1:0]   idx;
        logic               flag;
    } list_req_t;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   key;
        logic [GROUP_W-1:0] grp;
        logic               flag;
        logic [TOTAL_W-1:0] total;
    } list_reply_t;

    logic clk;
    logic rst_n;

    ukol_req_if req_ch ();
    ukol_rsp_if rsp_ch ();

    unique_key_ordered_list_core #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Requests still to be driven, and replies still owed by the block.
    list_req_t   request_queue[$];
    list_reply_t reply_queue[$];

    // Local copy of the list contents.
    entry_t      list_mem[LIST_DEPTH];
    int unsigned list_fill;

    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int unsigned error_count;
    int unsigned result_count;
    int unsigned cycle_count;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // List model: apply one request, return the reply it causes
    // ------------------------------------------------------------------------
    function automatic list_reply_t apply_list_op(list_req_t r);
        list_reply_t rs;
        int          pos;
        int          i;
        rs  = '0;
        pos = -1;
        // Search only the held entries; the first match wins.
        for (i = 0; i < int'(list_fill); i++)
        begin
            if (pos < 0 && list_mem[i].key == r.key)
                pos = i;
        end
        case (r.op)
            OP_ADD:
            begin
                // Append only with room left and the key absent.
                if (list_fill < LIST_DEPTH && pos < 0)
                begin
                    list_mem[list_fill].key  = r.key;
                    list_mem[list_fill].grp  = r.grp;
                    list_mem[list_fill].flag = 1'b0;
                    list_fill++;
                    rs.ok = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                // Compact: shift every later entry down one place.
                if (pos >= 0)
                begin
                    for (i = pos; i + 1 < int'(list_fill); i++)
                        list_mem[i] = list_mem[i + 1];
                    list_fill--;
                    rs.ok = 1'b1;
                end
            end
            OP_CONTAINS:
                rs.ok = (pos >= 0);
            OP_GET:
            begin
                if (r.idx < list_fill)
                begin
                    rs.key  = list_mem[r.idx].key;
                    rs.grp  = list_mem[r.idx].grp;
                    rs.flag = list_mem[r.idx].flag;
                    rs.ok   = 1'b1;
                end
            end
            OP_SET_FLAG:
            begin
                if (r.idx < list_fill)
                begin
                    list_mem[r.idx].flag = r.flag;
                    rs.ok = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                list_fill = 0;
                rs.ok     = 1'b1;
            end
            OP_CLEAR_FLAGS:
            begin
                for (i = 0; i < int'(list_fill); i++)
                    list_mem[i].flag = 1'b0;
                rs.ok = 1'b1;
            end
            default:
                ;
        endcase
        rs.total = list_fill[TOTAL_W-1:0];
        return rs;
    endfunction

    // ------------------------------------------------------------------------
    // Failure reporting
    // ------------------------------------------------------------------------
    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_error($sformatf("response %0d: %s got 0x%0h, want 0x%0h",
                                   result_count, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                            logic [GROUP_W-1:0] grp, logic [IDX_W-1:0] idx,
                            logic flag);
        list_req_t r;
        r.op   = op;
        r.key  = key;
        r.grp  = grp;
        r.idx  = idx;
        r.flag = flag;
        request_queue.push_back(r);
    endtask

    // Mostly a pool key, now and then a fresh one that is almost surely absent.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        if ($urandom_range(0, 9) == 0)
            k = KEY_W'($urandom());
        else
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return k;
    endfunction

    // Favor low positions, where entries are more likely to be held.
    function automatic logic [IDX_W-1:0] pick_index();
        logic [IDX_W-1:0] ix;
        if ($urandom_range(0, 1) == 0)
            ix = IDX_W'($urandom_range(0, 15));
        else
            ix = IDX_W'($urandom_range(0, LIST_DEPTH - 1));
        return ix;
    endfunction

    task automatic queue_random_op();
        int unsigned      pick;
        logic [OP_W-1:0]  op;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = OP_ADD;
        else if (pick < 50)
            op = OP_REMOVE;
        else if (pick < 65)
            op = OP_CONTAINS;
        else if (pick < 80)
            op = OP_GET;
        else if (pick < 90)
            op = OP_SET_FLAG;
        else if (pick < 94)
            op = OP_CLEAR_FLAGS;
        else if (pick < 97)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        queue_op(op, pick_key(), GROUP_W'($urandom()), pick_index(),
                 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned n;
        int unsigned start;
        int unsigned made;
        int unsigned kind;
        int unsigned i;
        bit          first;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_ADD;
        req_ch.item_key     = '0;
        req_ch.group_id     = '0;
        req_ch.entry_index  = '0;
        req_ch.flag_value   = 1'b0;
        rsp_ch.ready        = 1'b0;
        list_fill           = 0;
        error_count         = 0;
        result_count        = 0;
        cycle_count         = 0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom());

        // Directed: operations on the empty list first.
        queue_op(OP_GET,         '0, '0, '0, 1'b0);
        queue_op(OP_REMOVE,      '1, '0, '0, 1'b0);
        queue_op(OP_CONTAINS,    '0, '0, '0, 1'b0);
        queue_op(OP_SET_FLAG,    '0, '0, '0, 1'b1);
        queue_op(OP_CLEAR_FLAGS, '0, '0, '0, 1'b0);
        // Extreme keys and groups, then a duplicate add.
        queue_op(OP_ADD,         '0, '0, '0, 1'b0);
        queue_op(OP_ADD,         '1, '1, '1, 1'b1);
        queue_op(OP_ADD,         '0, '1, '0, 1'b0);
        queue_op(OP_ADD,         31'h2AAA_AAAA, 31'h5555_5555, '0, 1'b0);
        queue_op(OP_CONTAINS,    '1, '0, '0, 1'b0);
        // Flag write and read back, then out-of-range positions.
        queue_op(OP_SET_FLAG,    '0, '0, 6'd1, 1'b1);
        queue_op(OP_GET,         '0, '0, 6'd1, 1'b0);
        queue_op(OP_GET,         '0, '0, 6'd3, 1'b0);
        queue_op(OP_SET_FLAG,    '0, '0, '1, 1'b1);
        queue_op(OP_GET,         '0, '0, '1, 1'b0);
        queue_op(OP_UNUSED,      '1, '1, '1, 1'b1);
        // Clear the flags, then remove from the head so the rest shifts down.
        queue_op(OP_CLEAR_FLAGS, '0, '0, '0, 1'b0);
        queue_op(OP_GET,         '0, '0, 6'd1, 1'b0);
        queue_op(OP_REMOVE,      '0, '0, '0, 1'b0);
        queue_op(OP_GET,         '0, '0, 6'd0, 1'b0);
        queue_op(OP_GET,         '0, '0, 6'd1, 1'b0);
        queue_op(OP_REMOVE,      31'h2AAA_AAAA, '0, '0, 1'b0);
        queue_op(OP_REMOVE,      31'h2AAA_AAAA, '0, '0, 1'b0);
        queue_op(OP_CLEAR,       '0, '0, '0, 1'b0);
        queue_op(OP_CONTAINS,    '1, '0, '0, 1'b0);

        // Random: fill bursts can reach a full list, drain bursts exercise removes
        // at varied positions, mixed stretches add noise. Start with a fill.
        made  = 0;
        first = 1'b1;
        while (made < RANDOM_ITEMS)
        begin
            kind = first ? 0 : $urandom_range(0, 5);
            if (kind == 0)
            begin
                // Consecutive pool keys are distinct, so 70 of them overfill.
                n     = first ? 70 : $urandom_range(30, 72);
                start = $urandom_range(0, POOL_SIZE - 1);
                for (i = 0; i < n; i++)
                    queue_op(OP_ADD, key_pool[(start + i) % POOL_SIZE],
                             GROUP_W'($urandom()), IDX_W'($urandom()),
                             1'($urandom_range(0, 1)));
                for (i = 0; i < 6; i++)
                    queue_random_op();
                made += n + 6;
            end
            else if (kind == 1)
            begin
                n = $urandom_range(10, 40);
                for (i = 0; i < n; i++)
                    queue_op(OP_REMOVE, pick_key(), GROUP_W'($urandom()),
                             IDX_W'($urandom()), 1'($urandom_range(0, 1)));
                made += n;
            end
            else
            begin
                for (i = 0; i < 20; i++)
                    queue_random_op();
                made += 20;
            end
            first = 1'b0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Hold until every request is accepted and every reply has arrived.
        while (request_queue.size() > 0 || req_ch.valid)
            @(posedge clk);
        while (reply_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** unique_key_ordered_list_core: PASSED **");
        else
            $display("** unique_key_ordered_list_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request driver: hold a transaction until ready, model it on acceptance,
    // insert random gaps between transactions outside the tail of the run
    // ------------------------------------------------------------------------
    list_req_t   in_flight;
    int unsigned gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                reply_queue.push_back(apply_list_op(in_flight));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    in_flight = request_queue.pop_front();
                    req_ch.op          <= in_flight.op;
                    req_ch.item_key    <= in_flight.key;
                    req_ch.group_id    <= in_flight.grp;
                    req_ch.entry_index <= in_flight.idx;
                    req_ch.flag_value  <= in_flight.flag;
                    req_ch.valid       <= 1'b1;
                    // Schedule a gap to follow this transaction.
                    if (request_queue.size() >= TAIL_ITEMS && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 9);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: score each accepted transaction against the oldest
    // reply, and stall ready in random bursts. Quiet stretches have no stalls.
    // ------------------------------------------------------------------------
    list_reply_t want;
    int unsigned stall_left = 0;
    bit          rsp_quiet  = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (reply_queue.size() == 0)
                    report_error($sformatf("response %0d arrived with no request pending",
                                           result_count));
                else
                begin
                    want = reply_queue.pop_front();
                    check_field("ok",          64'(rsp_ch.ok),          64'(want.ok));
                    check_field("out_key",     64'(rsp_ch.out_key),     64'(want.key));
                    check_field("out_group",   64'(rsp_ch.out_group),   64'(want.grp));
                    check_field("out_flag",    64'(rsp_ch.out_flag),    64'(want.flag));
                    check_field("entry_total", 64'(rsp_ch.entry_total), 64'(want.total));
                end
                result_count++;
            end

            if (cycle_count % 512 == 0)
                rsp_quiet = ($urandom_range(0, 2) == 0);

            if (request_queue.size() < TAIL_ITEMS || rsp_quiet)
            begin
                stall_left = 0;
                rsp_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 15) == 0)
                    stall_left = $urandom_range(1, 9);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** unique_key_ordered_list_core: FAILED **");
            $finish;
        end
    end

endmodule

### unique_key_ordered_list_core.f
+incdir+sv
sv/ukol_pkg.sv
sv/ukol_if.sv
sv/ukol_entry_store.sv
sv/unique_key_ordered_list_core.sv
tb/sv/unique_key_ordered_list_core_tb.sv
